// ===== hdl/aes_pkg.sv =====
// Package for the AES-128 block encryptor: widths, S-box, GF(2^8) helpers,
// controller command and status structs. Depends on nothing.
package aes_pkg;

   localparam int unsigned Rounds   = 10;
   localparam int unsigned RoundW   = 4;   // holds 0..Rounds
   localparam int unsigned AddrW    = 4;   // csr byte address, registers at 8*i

   localparam logic [AddrW-1:0] ADDR_KEY_HIGH = 4'h0;
   localparam logic [AddrW-1:0] ADDR_KEY_LOW  = 4'h8;

   typedef struct packed {
      logic load;       // take plaintext and key words, add round key 0
      logic round;      // run one round
      logic last;       // final round, skip MixColumns
   } cmd_type;

   typedef struct packed {
      logic [RoundW-1:0] round;
   } status_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

endpackage

// ===== hdl/aes_ctrl.sv =====
// Sequencer for the AES-128 encryptor: handshake and round sequencing.
// Depends on aes_pkg.
module aes_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output aes_pkg::cmd_type      cmd,
   input  aes_pkg::status_type   status
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd       = '0;
      cmd.load  = accept;
      cmd.round = (state_ff == ST_RUN);
      cmd.last  = (state_ff == ST_RUN) &&
                  (status.round == aes_pkg::RoundW'(aes_pkg::Rounds));
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RUN;
         ST_RUN:  if (cmd.last) state_in = ST_DONE;
         ST_DONE: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end
endmodule

// ===== hdl/aes_datapath.sv =====
// State register, round logic and on-the-fly key schedule for AES-128.
// Depends on aes_pkg.
module aes_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  aes_pkg::cmd_type      cmd,
   output aes_pkg::status_type   status,
   input  logic [127:0]          key,
   input  logic [127:0]          block_in,
   output logic [127:0]          block_out
);
   logic [127:0] state_ff, state_in, rkey_ff, rkey_in, sb, sr, mc, nk;
   logic [7:0]   rcon_ff, rcon_in;
   logic [aes_pkg::RoundW-1:0] round_ff, round_in;
   logic [31:0]  tw;

   // byte i of the state sits at bits [127-8i -: 8]
   always_comb begin
      for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = aes_pkg::sbox(state_ff[127-8*i -: 8]);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            sr[127-8*(4*c+r) -: 8] = sb[127-8*(4*((c+r)%4)+r) -: 8];
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3, al;
         a0 = sr[127-32*c -: 8];  a1 = sr[119-32*c -: 8];
         a2 = sr[111-32*c -: 8];  a3 = sr[103-32*c -: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         mc[127-32*c -: 8] = a0 ^ al ^ aes_pkg::xtime(a0 ^ a1);
         mc[119-32*c -: 8] = a1 ^ al ^ aes_pkg::xtime(a1 ^ a2);
         mc[111-32*c -: 8] = a2 ^ al ^ aes_pkg::xtime(a2 ^ a3);
         mc[103-32*c -: 8] = a3 ^ al ^ aes_pkg::xtime(a3 ^ a0);
      end
      // next round key from the current one
      tw = {aes_pkg::sbox(rkey_ff[23:16]), aes_pkg::sbox(rkey_ff[15:8]),
            aes_pkg::sbox(rkey_ff[7:0]), aes_pkg::sbox(rkey_ff[31:24])} ^ {rcon_ff, 24'h0};
      nk[127:96] = rkey_ff[127:96] ^ tw;
      nk[95:64]  = rkey_ff[95:64] ^ nk[127:96];
      nk[63:32]  = rkey_ff[63:32] ^ nk[95:64];
      nk[31:0]   = rkey_ff[31:0] ^ nk[63:32];

      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      priority if (cmd.load) begin
         state_in = block_in ^ key;
         rkey_in  = key;
         rcon_in  = 8'h01;
         round_in = aes_pkg::RoundW'(1);
      end else if (cmd.round) begin
         state_in = (cmd.last ? sr : mc) ^ nk;
         rkey_in  = nk;
         rcon_in  = aes_pkg::xtime(rcon_ff);
         round_in = round_ff + aes_pkg::RoundW'(1);
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
      if (reset) round_ff <= '0;
      else       round_ff <= round_in;
   end

   assign status.round = round_ff;
   assign block_out    = state_ff;
endmodule

// ===== hdl/aes128_block_encrypt_top.sv =====
// AES-128 block encryptor. Each beat on req_ carries one 128-bit plaintext
// block; one ciphertext beat follows on rsp_. rsp_valid rises after the initial
// key addition on acceptance and ten rounds, one per cycle through a single
// round unit. A new block is accepted only once the result has been taken
// and the block is idle again. Round keys are derived on the fly
// from the key registers, so a key write takes effect on the next block.
// Write key_high at 0x0 and key_low at 0x8 over the 64-bit csr_ port.
// Depends on aes_pkg, aes_ctrl, aes_datapath.
module aes128_block_encrypt_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [63:0]                 req_plaintext_high,
   input  logic [63:0]                 req_plaintext_low,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [63:0]                 rsp_ciphertext_high,
   output logic [63:0]                 rsp_ciphertext_low,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [aes_pkg::AddrW-1:0]   csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output logic                        csr_pready
);
   logic [63:0]         key_high_ff, key_low_ff;
   logic                wr;
   aes_pkg::cmd_type    cmd;
   aes_pkg::status_type status;
   logic [127:0]        block_out;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // hold key registers; write on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (wr) begin
         if (csr_paddr == aes_pkg::ADDR_KEY_HIGH) key_high_ff <= csr_pwdata;
         if (csr_paddr == aes_pkg::ADDR_KEY_LOW)  key_low_ff  <= csr_pwdata;
      end
   end

   always_comb begin
      priority if (csr_paddr == aes_pkg::ADDR_KEY_HIGH) csr_prdata = key_high_ff;
      else if (csr_paddr == aes_pkg::ADDR_KEY_LOW)      csr_prdata = key_low_ff;
      else                                              csr_prdata = '0;
   end

   aes_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .status
   );

   aes_datapath u_dp (
      .clock, .reset, .cmd, .status,
      .key      ({key_high_ff, key_low_ff}),
      .block_in ({req_plaintext_high, req_plaintext_low}),
      .block_out
   );

   assign rsp_ciphertext_high = block_out[127:64];
   assign rsp_ciphertext_low  = block_out[63:0];
endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the AES-128 block encryptor: random and directed
// plaintext beats, key writes over the csr_ port, scoreboard against a local cipher.
// Depends on aes_pkg (csr addresses) and aes128_block_encrypt_top.
module testbench;

   localparam int unsigned IdleLimit = 20000;
   localparam int unsigned RandomBlocks = 1550;

   typedef struct packed {
      logic [63:0] high;
      logic [63:0] low;
   } block_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [63:0]                req_plaintext_high = '0;
   logic [63:0]                req_plaintext_low = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [63:0]                rsp_ciphertext_high;
   logic [63:0]                rsp_ciphertext_low;
   logic                       csr_psel = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite = 1'b0;
   logic [aes_pkg::AddrW-1:0]  csr_paddr = '0;
   logic [63:0]                csr_pwdata = '0;
   logic [63:0]                csr_prdata;
   logic                       csr_pready;

   aes128_block_encrypt_top DUT (.*);

   // Predictor state: the key registers and its own expanded schedule.
   logic [63:0] cipher_key_high = '0;
   logic [63:0] cipher_key_low = '0;
   logic [31:0] schedule [44];
   bit          schedule_valid = 1'b0;

   block_type   pending_blocks [$];
   block_type   expected_ciphertexts [$];
   bit          failed = 1'b0;
   bit          quiet = 1'b0;      // no idling on either side near the end
   int unsigned idle_cycles = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [7:0] sub_byte(input logic [7:0] x);
      logic [7:0] p, q, inv;
      // multiplicative inverse by brute force search, then the affine map
      inv = 8'h00;
      for (int i = 1; i < 256; i++) begin
         p = 8'(i);
         q = 8'h00;
         for (int b = 0; b < 8; b++) begin
            if (x[b]) q = q ^ p;
            p = {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
         end
         if (q == 8'h01) inv = 8'(i);
      end
      return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
   endfunction

   logic [7:0] sub_lut [256];
   initial begin
      for (int i = 0; i < 256; i++) sub_lut[i] = sub_byte(8'(i));
   end

   function automatic logic [7:0] gf_twice(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   task automatic expand_schedule();
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      schedule[0] = cipher_key_high[63:32];
      schedule[1] = cipher_key_high[31:0];
      schedule[2] = cipher_key_low[63:32];
      schedule[3] = cipher_key_low[31:0];
      for (int i = 4; i < 44; i++) begin
         t = schedule[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sub_lut[t[31:24]], sub_lut[t[23:16]], sub_lut[t[15:8]], sub_lut[t[7:0]]}
                ^ {rc, 24'h0};
            rc = gf_twice(rc);
         end
         schedule[i] = schedule[i-4] ^ t;
      end
      schedule_valid = 1'b1;
   endtask

   task automatic encrypt_block(input block_type plain, output block_type cipher);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] flat;
      if (!schedule_valid) expand_schedule();
      flat = {plain.high, plain.low};
      for (int i = 0; i < 16; i++) s[i] = flat[127-8*i -: 8];
      for (int round = 0; round <= 10; round++) begin
         if (round > 0) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  t[4*c+r] = sub_lut[s[4*((c+r)%4)+r]];
            s = t;
            if (round < 10) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                  all = a0 ^ a1 ^ a2 ^ a3;
                  s[4*c]   = a0 ^ all ^ gf_twice(a0 ^ a1);
                  s[4*c+1] = a1 ^ all ^ gf_twice(a1 ^ a2);
                  s[4*c+2] = a2 ^ all ^ gf_twice(a2 ^ a3);
                  s[4*c+3] = a3 ^ all ^ gf_twice(a3 ^ a0);
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               s[4*c+r] = s[4*c+r] ^ schedule[4*round+c][31-8*r -: 8];
      end
      for (int i = 0; i < 16; i++) flat[127-8*i -: 8] = s[i];
      cipher = flat;
   endtask

   // Driver: present the head of the pending queue, hold it while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) pending_blocks.pop_front();
         if (req_valid && req_stall) begin
            // hold the stalled beat
         end else if (send_gap > 0 && !quiet) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_blocks.size() > 0) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
               send_gap <= $urandom_range(1, 17) - 1;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_plaintext_high <= pending_blocks[0].high;
               req_plaintext_low <= pending_blocks[0].low;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Predict on acceptance; the key in force is the one written before.
   always @(posedge clock) begin
      block_type c;
      if (!reset && req_valid && !req_stall) begin
         encrypt_block({req_plaintext_high, req_plaintext_low}, c);
         expected_ciphertexts.push_back(c);
      end
   end

   // Receiver stall bursts, dropped in the quiet tail.
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         recv_gap <= 0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_stall <= (recv_gap > 1);
      end else if ($urandom_range(0, 11) == 0) begin
         recv_gap <= $urandom_range(1, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: compare each accepted ciphertext with the oldest expectation.
   always @(posedge clock) begin
      block_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_ciphertexts.size() == 0) begin
            $display("%0t: unexpected ciphertext %h %h", $time,
                     rsp_ciphertext_high, rsp_ciphertext_low);
            failed = 1'b1;
         end else begin
            e = expected_ciphertexts.pop_front();
            if (rsp_ciphertext_high !== e.high) begin
               $display("%0t: ciphertext_high expected %h actual %h", $time,
                        e.high, rsp_ciphertext_high);
               failed = 1'b1;
            end
            if (rsp_ciphertext_low !== e.low) begin
               $display("%0t: ciphertext_low expected %h actual %h", $time,
                        e.low, rsp_ciphertext_low);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog: count cycles with no beat on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_blocks.size() > 0 || req_valid || expected_ciphertexts.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Write one key register: setup then access cycle. The predictor takes the
   // value at the access edge.
   task automatic write_key(input bit low_half, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= low_half ? aes_pkg::ADDR_KEY_LOW : aes_pkg::ADDR_KEY_HIGH;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (low_half) cipher_key_low = value; else cipher_key_high = value;
      schedule_valid = 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_blocks(input int unsigned count);
      for (int i = 0; i < count; i++)
         pending_blocks.push_back({rand64(), rand64()});
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Blocks under the reset key of all zeros, with extreme plaintexts.
      pending_blocks.push_back({64'h0, 64'h0});
      pending_blocks.push_back({64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff});
      pending_blocks.push_back({64'h0, 64'hffff_ffff_ffff_ffff});
      wait_drained();

      // FIPS-197 appendix key with two plaintexts, then extreme keys.
      write_key(1'b0, 64'h2b7e_1516_28ae_d2a6);
      write_key(1'b1, 64'habf7_1588_09cf_4f3c);
      pending_blocks.push_back({64'h3243_f6a8_885a_308d, 64'h3132_9807_34a2_e037});
      pending_blocks.push_back({64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff});
      wait_drained();
      write_key(1'b0, 64'hffff_ffff_ffff_ffff);
      write_key(1'b1, 64'hffff_ffff_ffff_ffff);
      pending_blocks.push_back({64'h0, 64'h0});
      pending_blocks.push_back({64'h8000_0000_0000_0000, 64'h1});
      wait_drained();
      // Half-updated key is used as it stands.
      write_key(1'b0, 64'h0);
      pending_blocks.push_back({64'hffff_ffff_ffff_ffff, 64'h0});
      wait_drained();

      // Random phases, each under a fresh (sometimes half-written) key.
      for (int phase = 0; phase < 10; phase++) begin
         if (phase % 3 != 2) write_key(1'b0, rand64());
         if (phase % 3 != 1) write_key(1'b1, rand64());
         queue_blocks(RandomBlocks / 10 - 15);
         wait_drained();
      end
      quiet = 1'b1;
      write_key(1'b0, rand64());
      write_key(1'b1, rand64());
      queue_blocks(100);
      wait_drained();

      if (!failed) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/aes_pkg.sv
hdl/aes_ctrl.sv
hdl/aes_datapath.sv
hdl/aes128_block_encrypt_top.sv
verif/testbench.sv
